// ===== sv/osa_pkg.sv =====
// ----------------------------------------------------------------------------
// osa_pkg
// shared types and fixed widths of the online softmax attention unit
// ----------------------------------------------------------------------------
package osa_pkg;

  localparam int ELEM_W = 16;   // q7.8 elements
  localparam int ACC_W  = 40;   // accumulator width
  localparam int SUM_W  = 32;   // running sum, q17.15
  localparam int WGT_W  = 16;   // weights, q1.15
  localparam int IDX_W  = 6;

  localparam logic [WGT_W-1:0] ONE_Q15 = 16'd32768;

  typedef enum logic [1:0] {
    REQ_QUERY = 2'd0,
    REQ_KEY   = 2'd1,
    REQ_VALUE = 2'd2,
    REQ_READ  = 2'd3
  } req_e;

  typedef enum logic {
    REG_LENGTH = 1'b0,
    REG_SCALE  = 1'b1
  } reg_e;

endpackage

// ===== sv/osa_div.sv =====
// ----------------------------------------------------------------------------
// osa_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module osa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [osa_pkg::ACC_W-1:0]   dividend_i,
  input  logic [osa_pkg::SUM_W-1:0]   divisor_i,
  output logic                        done_o,
  output logic [osa_pkg::ACC_W-1:0]   quotient_o
);
  import osa_pkg::*;

  localparam int CW = $clog2(ACC_W + 1);

  logic            run_q, run_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [ACC_W-1:0] quo_q, quo_d;
  logic [SUM_W-1:0] rem_q, rem_d;
  logic [SUM_W-1:0] div_q;
  logic            done_q, done_d;
  logic [SUM_W:0]   shifted;

  assign shifted = {rem_q, quo_q[ACC_W-1]};

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    done_d = 1'b0;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      quo_d = dividend_i;
      rem_d = '0;
    end else if (run_q) begin
      if (shifted >= {1'b0, div_q}) begin
        rem_d = SUM_W'(shifted - {1'b0, div_q});
        quo_d = {quo_q[ACC_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[SUM_W-1:0];
        quo_d = {quo_q[ACC_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == CW'(ACC_W - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      div_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> run_q && !done_q) else $error("divider start not taken");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !run_q && $past(run_q)) else $error("divider done without run");
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q && !$past(start_i) |-> rem_q < div_q) else $error("remainder out of range");

endmodule

// ===== sv/online_softmax_attention_unit.sv =====
// ----------------------------------------------------------------------------
// online_softmax_attention_unit
// one query row of attention with a running-max (online) softmax
// ----------------------------------------------------------------------------
// usage:
//   an item (req_type, elem_index, elem_value) is taken when start_i is high
//   and busy_o is low. query items write the query memory; query element 0
//   also clears the row (running max, sum, weights, all accumulators). key
//   items pass through the query memory read and the dot product mac; the
//   last key element of a row adds the score multiply, max update, exp table
//   lookup and sum rescale steps (the first key row of a row needs no table
//   lookup and skips it). value items pass through accumulator memory read,
//   multiply and write back. read items run the 40 bit bit-serial divider and
//   give one result on out_index_o/out_value_o with out_valid_o high for
//   exactly one cycle; the receiver cannot stall it.
//   registers (apb, pready always high): 0x0 vector_length, 0x4 score_scale.
//   write them only while busy_o is low.
//   reset: length 64, scale 512, row cleared through accumulator valid bits;
//   no clearing pass is needed, the block is ready right after reset.
// ----------------------------------------------------------------------------
module online_softmax_attention_unit #(
  parameter int VEC_DEPTH       = 64,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item channel
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   req_type_i,
  input  logic [osa_pkg::IDX_W-1:0]    elem_index_i,
  input  logic signed [osa_pkg::ELEM_W-1:0] elem_value_i,
  // result channel
  output logic                         out_valid_o,
  output logic [osa_pkg::IDX_W-1:0]    out_index_o,
  output logic signed [osa_pkg::ELEM_W-1:0] out_value_o,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import osa_pkg::*;

  localparam int AW = $clog2(VEC_DEPTH);
  localparam int TW = $clog2(EXP_TABLE_DEPTH);
  localparam int DW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam logic [63:0] STEP = (64'd16 << 30) / EXP_TABLE_DEPTH;

  typedef logic [WGT_W-1:0] wtab_t [EXP_TABLE_DEPTH];

  // exp(-k*step) table, q1.15, built at elaboration
  function automatic wtab_t build_tab();
    wtab_t       t;
    logic [63:0] term;
    longint      r;
    logic [63:0] e;
    term = 64'd1 << 30;
    r    = longint'(1) << 30;
    e    = 64'd1 << 30;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * STEP) >> 30) / 64'(n);
      if (n % 2 == 1) r = r - longint'(term);
      else            r = r + longint'(term);
    end
    if (r < 0) r = 0;
    if (r > (longint'(1) << 30)) r = longint'(1) << 30;
    for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
      t[k] = WGT_W'((e + 64'd16384) >> 15);
      e    = (e * 64'(r) + (64'd1 << 29)) >> 30;
    end
    return t;
  endfunction

  localparam wtab_t EXP_TAB = build_tab();

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_KEY  = 10'b0000000010,
    S_SMUL = 10'b0000000100,
    S_SMAX = 10'b0000001000,
    S_SLUT = 10'b0000010000,
    S_SSUM = 10'b0000100000,
    S_ARD  = 10'b0001000000,
    S_VWR  = 10'b0010000000,
    S_DIV  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [6:0]  vlen_q;
  logic [15:0] scale_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlen_q  <= 7'd64;
      scale_q <= 16'd512;
    end else if (cfg_wr) begin
      case (reg_e'(paddr[2]))
        REG_LENGTH: vlen_q  <= pwdata[6:0];
        REG_SCALE:  scale_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_e'(paddr[2]))
      REG_LENGTH: prdata = {25'd0, vlen_q};
      REG_SCALE:  prdata = {16'd0, scale_q};
      default:    prdata = '0;
    endcase
  end

  // effective length, zero acts as one, clipped to the store depth
  logic [8:0] len;
  always_comb begin
    if (vlen_q == 7'd0)                     len = 9'd1;
    else if (int'(vlen_q) > VEC_DEPTH)      len = 9'(VEC_DEPTH);
    else                                    len = {2'd0, vlen_q};
  end

  // item acceptance
  logic         accept;
  logic         in_range;
  logic [AW-1:0] in_addr;
  req_e         in_type;

  assign busy_o   = (state_q != S_IDLE);
  assign accept   = start_i && !busy_o;
  assign in_range = int'(elem_index_i) < VEC_DEPTH;
  assign in_addr  = AW'(elem_index_i);
  assign in_type  = req_e'(req_type_i);

  // latched item
  req_e                    type_q;
  logic [IDX_W-1:0]        idx_q;
  logic signed [ELEM_W-1:0] val_q;
  logic                    range_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      type_q  <= in_type;
      idx_q   <= elem_index_i;
      val_q   <= elem_value_i;
      range_q <= in_range;
    end
  end

  // query memory, undefined until written
  logic signed [ELEM_W-1:0] qmem [VEC_DEPTH];
  logic signed [ELEM_W-1:0] q_rdata_q;

  always_ff @(posedge clk_i) begin
    if (accept && in_range && in_type == REQ_QUERY) begin
      qmem[in_addr] <= elem_value_i;
    end
    if (accept) begin
      q_rdata_q <= qmem[in_addr];
    end
  end

  // accumulator memory with per-entry valid bits, invalid reads as zero
  logic signed [ACC_W-1:0] amem [VEC_DEPTH];
  logic signed [ACC_W-1:0] a_rdata_q;
  logic [VEC_DEPTH-1:0]    acc_vld_q;
  logic                    a_vld_rd_q;
  logic signed [ACC_W-1:0] acc_rd;
  logic signed [ACC_W-1:0] acc_wr;
  logic                    row_clear;

  assign row_clear = accept && in_range && in_type == REQ_QUERY && elem_index_i == '0;
  assign acc_rd    = a_vld_rd_q ? a_rdata_q : '0;

  always_ff @(posedge clk_i) begin
    if (state_q == S_VWR) begin
      amem[AW'(idx_q)] <= acc_wr;
    end
    if (accept) begin
      a_rdata_q  <= amem[in_addr];
      a_vld_rd_q <= acc_vld_q[in_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_vld_q <= '0;
    end else if (row_clear) begin
      acc_vld_q <= '0;
    end else if (state_q == S_VWR) begin
      acc_vld_q[AW'(idx_q)] <= 1'b1;
    end
  end

  // row state
  logic signed [ACC_W-1:0] dot_q;
  logic signed [31:0]      max_q;
  logic [SUM_W-1:0]        sum_q;
  logic [WGT_W-1:0]        wold_q, wnew_q;
  logic                    seen_q;

  // key datapath
  logic signed [31:0]      kprod;
  logic signed [ACC_W:0]   dot_add;
  logic signed [ACC_W-1:0] dot_next;

  assign kprod   = q_rdata_q * val_q;
  assign dot_add = (idx_q == '0) ? (ACC_W+1)'(kprod) : (ACC_W+1)'(dot_q) + (ACC_W+1)'(kprod);

  always_comb begin
    if (dot_add > $signed((ACC_W+1)'({1'b0, {(ACC_W-1){1'b1}}})))
      dot_next = {1'b0, {(ACC_W-1){1'b1}}};
    else if (dot_add < -$signed((ACC_W+1)'({1'b0, {(ACC_W-1){1'b1}}})) - (ACC_W+1)'(1))
      dot_next = {1'b1, {(ACC_W-1){1'b0}}};
    else
      dot_next = ACC_W'(dot_add);
  end

  // score: dot * scale, floor >> 20, saturated to 32 bits
  logic signed [ACC_W+16:0] sprod_q;
  logic signed [ACC_W-4:0]  sshift;
  logic signed [31:0]       score;
  logic signed [31:0]       mnew;
  logic signed [32:0]       d_old, d_new;

  assign sshift = sprod_q[ACC_W+16:20];

  always_comb begin
    if (sshift > (ACC_W-3)'(32'sh7fffffff))         score = 32'sh7fffffff;
    else if (sshift < -(ACC_W-3)'(32'sh7fffffff) - (ACC_W-3)'(1)) score = 32'sh80000000;
    else                                            score = 32'(sshift);
  end

  assign mnew  = (score > max_q) ? score : max_q;
  assign d_old = 33'(mnew) - 33'(max_q);
  assign d_new = 33'(mnew) - 33'(score);

  // exp table index: floor(d * depth / 4096), zero weight from 16.0 up
  logic [11+DW:0] lut_old_m, lut_new_m;
  logic [TW-1:0]  lut_old_q, lut_new_q;
  logic           zero_old_q, zero_new_q;

  assign lut_old_m = {{DW{1'b0}}, d_old[11:0]} * (12+DW)'(EXP_TABLE_DEPTH);
  assign lut_new_m = {{DW{1'b0}}, d_new[11:0]} * (12+DW)'(EXP_TABLE_DEPTH);

  // running sum rescale
  logic [SUM_W+WGT_W-1:0] sum_prod;
  logic [SUM_W+1:0]       sum_next;
  assign sum_prod = sum_q * wold_q;
  assign sum_next = (SUM_W+2)'((sum_prod + (SUM_W+WGT_W)'(16384)) >> 15) + (SUM_W+2)'(wnew_q);

  // value datapath
  logic signed [ACC_W+16:0] vp_old_q;
  logic signed [ELEM_W+16:0] vp_new_q;
  logic signed [ACC_W+1:0]  v_round;
  logic signed [ACC_W+2:0]  v_sum;

  assign v_round = (ACC_W+2)'((vp_old_q + (ACC_W+17)'(16384)) >>> 15);
  assign v_sum   = (ACC_W+3)'(v_round) + (ACC_W+3)'(vp_new_q);

  always_comb begin
    if (v_sum > $signed((ACC_W+3)'({1'b0, {(ACC_W-1){1'b1}}})))
      acc_wr = {1'b0, {(ACC_W-1){1'b1}}};
    else if (v_sum < -$signed((ACC_W+3)'({1'b0, {(ACC_W-1){1'b1}}})) - (ACC_W+3)'(1))
      acc_wr = {1'b1, {(ACC_W-1){1'b0}}};
    else
      acc_wr = ACC_W'(v_sum);
  end

  // read path through the divider
  logic              div_start, div_done;
  logic [ACC_W-1:0]  div_quo;
  logic [ACC_W-1:0]  mag;
  logic              neg_q;
  logic              rd_zero_q;

  assign mag       = acc_rd[ACC_W-1] ? ACC_W'(-acc_rd) : ACC_W'(acc_rd);
  assign div_start = (state_q == S_ARD) && type_q == REQ_READ && range_q;

  osa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (mag),
    .divisor_i  ((sum_q == '0) ? SUM_W'(ONE_Q15) : sum_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_ff @(posedge clk_i) begin
    if (div_start) neg_q <= acc_rd[ACC_W-1];
  end

  // result, clipped to q7.8
  always_comb begin
    if (rd_zero_q)                               out_value_o = '0;
    else if (neg_q && div_quo >= ACC_W'(32768))  out_value_o = 16'sh8000;
    else if (neg_q)                              out_value_o = ELEM_W'(-div_quo);
    else if (div_quo >= ACC_W'(32767))           out_value_o = 16'sh7fff;
    else                                         out_value_o = ELEM_W'(div_quo);
  end

  assign out_valid_o = (state_q == S_OUT);
  assign out_index_o = idx_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_type)
            REQ_KEY: begin
              if (in_range && {3'd0, elem_index_i} < len) state_d = S_KEY;
            end
            REQ_VALUE: begin
              if (in_range) state_d = S_ARD;
            end
            REQ_READ: state_d = S_ARD;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_KEY:  state_d = ({3'd0, idx_q} == len - 9'd1) ? S_SMUL : S_IDLE;
      S_SMUL: state_d = S_SMAX;
      S_SMAX: state_d = seen_q ? S_SLUT : S_SSUM;
      S_SLUT: state_d = S_SSUM;
      S_SSUM: state_d = S_IDLE;
      S_ARD: begin
        if (type_q == REQ_VALUE) state_d = S_VWR;
        else if (range_q)        state_d = S_DIV;
        else                     state_d = S_OUT;
      end
      S_VWR:  state_d = S_IDLE;
      S_DIV:  state_d = div_done ? S_OUT : S_DIV;
      S_OUT:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      dot_q   <= '0;
      max_q   <= '0;
      sum_q   <= '0;
      wold_q  <= '0;
      wnew_q  <= '0;
      seen_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (row_clear) begin
        dot_q  <= '0;
        max_q  <= '0;
        sum_q  <= '0;
        wold_q <= '0;
        wnew_q <= '0;
        seen_q <= 1'b0;
      end
      case (state_q)
        S_KEY: dot_q <= dot_next;
        S_SMAX: begin
          // first key row sets the max outright
          if (!seen_q) begin
            max_q  <= score;
            wold_q <= '0;
            wnew_q <= ONE_Q15;
          end else begin
            max_q <= mnew;
          end
          seen_q <= 1'b1;
        end
        S_SLUT: begin
          wold_q <= zero_old_q ? '0 : EXP_TAB[lut_old_q];
          wnew_q <= zero_new_q ? '0 : EXP_TAB[lut_new_q];
        end
        S_SSUM: sum_q <= (sum_next > (SUM_W+2)'({SUM_W{1'b1}})) ? {SUM_W{1'b1}}
                                                                : SUM_W'(sum_next);
        default: ;
      endcase
    end
  end

  // datapath pipeline registers
  always_ff @(posedge clk_i) begin
    if (state_q == S_SMUL) begin
      sprod_q <= dot_q * $signed({1'b0, scale_q});
    end
    if (state_q == S_SMAX) begin
      zero_old_q <= d_old >= 33'sd4096;
      zero_new_q <= d_new >= 33'sd4096;
      lut_old_q  <= lut_old_m[TW+11:12];
      lut_new_q  <= lut_new_m[TW+11:12];
    end
    if (state_q == S_ARD) begin
      vp_old_q  <= acc_rd * $signed({1'b0, wold_q});
      vp_new_q  <= val_q * $signed({1'b0, wnew_q});
      rd_zero_q <= !range_q;
    end
  end

  // checks
  a_out_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $past(busy_o)) else $error("result without a pending read");
  a_read_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_type == REQ_READ |=> busy_o) else $error("read item not started");
  a_row_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_clear |=> acc_vld_q == '0 && !seen_q) else $error("row clear incomplete");
  a_div_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> type_q == REQ_READ) else $error("divider used outside read");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench of the online softmax attention unit
// ----------------------------------------------------------------------------
// drives query, key, value and read items through the start/busy channel,
// predicts every read with an own fixed point model of the running max
// softmax and compares each strobed result with the oldest expectation
// ----------------------------------------------------------------------------
module tb;
  import osa_pkg::*;

  localparam int HD     = 64;
  localparam int EDEPTH = 256;
  localparam longint ACC_HI = 64'sd549755813887;
  localparam longint ACC_LO = -64'sd549755813888;

  // scoreboard of expected read results
  class read_board;
    logic [IDX_W-1:0]  exp_idx[$];
    logic [ELEM_W-1:0] exp_val[$];
    int errors;

    function void note(logic [IDX_W-1:0] idx, logic [ELEM_W-1:0] val);
      exp_idx.push_back(idx);
      exp_val.push_back(val);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check(logic [IDX_W-1:0] idx, logic [ELEM_W-1:0] val);
      logic [IDX_W-1:0]  ei;
      logic [ELEM_W-1:0] ev;
      if (exp_idx.size() == 0) begin
        report($sformatf("unexpected result index %0d value %0d", idx, $signed(val)));
        return;
      end
      ei = exp_idx.pop_front();
      ev = exp_val.pop_front();
      if (ei !== idx) begin
        report($sformatf("out_index %0d, expected %0d", idx, ei));
      end
      if (ev !== val) begin
        report($sformatf("out_value %0d at index %0d, expected %0d",
                         $signed(val), ei, $signed(ev)));
      end
    endtask
  endclass

  logic clk, rst_n;
  logic start, busy;
  logic [1:0] req_type;
  logic [IDX_W-1:0] elem_index;
  logic signed [ELEM_W-1:0] elem_value;
  logic out_valid;
  logic [IDX_W-1:0] out_index;
  logic signed [ELEM_W-1:0] out_value;
  logic psel, penable, pwrite, pready;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;

  online_softmax_attention_unit i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .start_i(start), .busy_o(busy),
    .req_type_i(req_type), .elem_index_i(elem_index), .elem_value_i(elem_value),
    .out_valid_o(out_valid), .out_index_o(out_index), .out_value_o(out_value),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  read_board board;

  // predictor state
  longint exp_tab[EDEPTH];
  int     len_reg, scale_reg;
  longint acc_mem[HD];
  longint dot_acc, run_max, run_sum, w_old, w_new;
  bit     key_seen;
  longint query_mem[HD];
  bit     query_ok[HD];

  int sender_idle;   // percent

  function automatic longint floor_sh(longint x, int n);
    return x >>> n;   // arithmetic shift is floor
  endfunction

  function automatic longint sat40(longint x);
    if (x > ACC_HI) return ACC_HI;
    if (x < ACC_LO) return ACC_LO;
    return x;
  endfunction

  function automatic void build_exp_table();
    longint unsigned s, term, e;
    longint r;
    s = (64'd16 << 30) / EDEPTH;
    term = 64'd1 << 30;
    r = 64'sd1 << 30;
    e = 64'd1 << 30;
    for (int n = 1; n <= 16; n++) begin
      term = ((term * s) >> 30) / n;
      if (n % 2) r -= longint'(term); else r += longint'(term);
    end
    if (r < 0) r = 0;
    if (r > (64'sd1 << 30)) r = 64'sd1 << 30;
    for (int k = 0; k < EDEPTH; k++) begin
      exp_tab[k] = longint'(e);
      e = (e * longint'(r) + (64'd1 << 29)) >> 30;
    end
  endfunction

  function automatic longint exp_weight(longint d);
    longint idx;
    if (d < 0) d = 0;
    if (d >= 4096) return 0;
    idx = (d * EDEPTH) / 4096;
    return (exp_tab[idx] + (1 << 14)) >> 15;
  endfunction

  function automatic void clear_row();
    foreach (acc_mem[i]) acc_mem[i] = 0;
    dot_acc = 0; run_max = 0; run_sum = 0; w_old = 0; w_new = 0;
    key_seen = 0;
  endfunction

  function automatic void close_key_row();
    longint p, m, s;
    p = floor_sh(dot_acc * longint'(scale_reg), 20);
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    if (!key_seen) begin
      run_max = p; w_old = 0; w_new = 32768;
    end else begin
      m = (p > run_max) ? p : run_max;
      w_old = exp_weight(m - run_max);
      w_new = exp_weight(m - p);
      run_max = m;
    end
    key_seen = 1;
    s = ((run_sum * w_old + (1 << 14)) >>> 15) + w_new;
    run_sum = (s > 64'sd4294967295) ? 64'sd4294967295 : s;
  endfunction

  // predicts the effect of one accepted item
  function automatic void predict_item(req_e t, int idx, longint v);
    int len;
    longint a, mag, q, dv;
    len = (len_reg == 0) ? 1 : ((len_reg > HD) ? HD : len_reg);
    case (t)
      REQ_READ: begin
        a = acc_mem[idx];
        dv = (run_sum != 0) ? run_sum : 32768;
        mag = (a < 0) ? -a : a;
        q = mag / dv;
        if (q > 32768) q = 32768;
        if (a < 0) q = -q;
        if (q > 32767) q = 32767;
        board.note(idx[IDX_W-1:0], q[ELEM_W-1:0]);
      end
      REQ_QUERY: begin
        if (idx == 0) clear_row();
        query_mem[idx] = v;
        query_ok[idx] = 1;
      end
      REQ_KEY: begin
        if (idx < len) begin
          dot_acc = sat40((idx == 0) ? query_mem[idx] * v : dot_acc + query_mem[idx] * v);
          if (idx == len - 1) close_key_row();
        end
      end
      default: begin
        a = floor_sh(acc_mem[idx] * w_old + (1 << 14), 15);
        acc_mem[idx] = sat40(a + v * w_new);
      end
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // results are strobed for one cycle and taken at the edge closing it
  always @(posedge clk) begin
    if (rst_n && out_valid) board.check(out_index, out_value);
  end

  // one item, with optional idle cycles in front; start stays high after
  // the accepting edge until the next item, a drain or a register write
  task automatic send_item(req_e t, int idx, logic [15:0] v);
    int len;
    len = (len_reg == 0) ? 1 : ((len_reg > HD) ? HD : len_reg);
    while (sender_idle > 0 && $urandom_range(99) < sender_idle) begin
      start <= 1'b0;
      @(posedge clk);
    end
    // a key inside the row must never read a query entry that was never written
    if (t == REQ_KEY && idx < len && !query_ok[idx]) t = REQ_VALUE;
    start      <= 1'b1;
    req_type   <= t;
    elem_index <= idx[IDX_W-1:0];
    elem_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_item(t, idx, longint'($signed(v)));
  endtask

  task automatic drain();
    start <= 1'b0;
    while (board.exp_idx.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic reg_write(reg_e r, int val);
    start <= 1'b0;
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= {r, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
    if (r == REG_LENGTH) len_reg = val & 8'h7f; else scale_reg = val & 16'hffff;
  endtask

  function automatic logic [15:0] rand_elem();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(1024)) - 512);
    endcase
  endfunction

  // query row, some key/value rows, reads of randomly chosen output elements
  task automatic attention_pass(int rows);
    int len;
    len = (len_reg == 0) ? 1 : ((len_reg > HD) ? HD : len_reg);
    for (int i = 0; i < len; i++) send_item(REQ_QUERY, i, rand_elem());
    for (int r = 0; r < rows; r++) begin
      for (int i = 0; i < len; i++) send_item(REQ_KEY, i, rand_elem());
      for (int i = 0; i < len; i++)
        if ($urandom_range(9) != 0) send_item(REQ_VALUE, i, rand_elem());
      // noise: stray items
      if ($urandom_range(3) == 0)
        send_item(req_e'($urandom_range(2)), $urandom_range(63), 16'($urandom));
    end
    for (int i = 0; i < len; i++)
      if ($urandom_range(2) != 0) send_item(REQ_READ, i, 16'($urandom));
  endtask

  int lens[6] = '{1, 4, 0, 2, 7, 3};
  int scales[6] = '{512, 65535, 4096, 0, 12000, 2048};

  initial begin
    board = new();
    rst_n = 0; start = 0; req_type = REQ_QUERY; elem_index = 0; elem_value = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    sender_idle = 0;
    len_reg = 64; scale_reg = 512;
    foreach (query_ok[i]) query_ok[i] = 0;
    build_exp_table();
    clear_row();
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: reads on a cleared row, then a short row at extremes
    send_item(REQ_READ, 0, 16'h0000);
    send_item(REQ_READ, 63, 16'hffff);
    drain();
    reg_write(REG_LENGTH, 2);
    reg_write(REG_SCALE, 65535);
    send_item(REQ_QUERY, 0, 16'h7fff);
    send_item(REQ_QUERY, 1, 16'h8000);
    send_item(REQ_KEY, 0, 16'h7fff);
    send_item(REQ_KEY, 1, 16'h8000);
    send_item(REQ_KEY, 5, 16'h1234);      // beyond length, ignored
    send_item(REQ_VALUE, 0, 16'h7fff);
    send_item(REQ_VALUE, 1, 16'h8000);
    send_item(REQ_KEY, 0, 16'h8000);
    send_item(REQ_KEY, 1, 16'h8000);
    send_item(REQ_VALUE, 0, 16'h8000);
    send_item(REQ_READ, 0, 16'h0);
    send_item(REQ_READ, 1, 16'h0);
    send_item(REQ_READ, 40, 16'h0);       // accumulator never visited
    drain();
    reg_write(REG_LENGTH, 127);           // above the store depth
    reg_write(REG_SCALE, 0);
    attention_pass(1);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: sender_idle = 0;
        1: sender_idle = 55;
        2: sender_idle = 0;
        default: sender_idle = 33;
      endcase
      reg_write(REG_LENGTH, lens[ph % 6]);
      reg_write(REG_SCALE, (ph > 5) ? $urandom_range(65535) : scales[ph]);
      attention_pass($urandom_range(1, 3));
      drain();   // sender holds off until every read has come back
    end

    drain();
    if (board.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
